>>> hdl/matrix_multiply_4x4_top_assert.svh
// Assertion macros used by the checker file mm4_checker.sv.
`ifndef MATRIX_MULTIPLY_4X4_TOP_ASSERT_SVH
`define MATRIX_MULTIPLY_4X4_TOP_ASSERT_SVH

// Antecedent holds in this cycle, consequent holds in the same cycle.
`define MM4_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent holds in this cycle, consequent holds in the next cycle.
`define MM4_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/mm4_pkg.sv
`timescale 1ns / 1ps

package mm4_pkg;

    localparam int DIM         = 4;
    localparam int N_ELEM      = DIM * DIM;
    localparam int IDX_W       = $clog2(N_ELEM);
    localparam int K_W         = $clog2(DIM);
    localparam int STEP_W      = IDX_W + K_W;
    localparam int ELEM_W      = 32;
    localparam int PROD_W      = 2 * ELEM_W;
    localparam int ACC_W       = PROD_W + K_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [IDX_W-1:0]  LAST_POS  = IDX_W'(N_ELEM - 1);
    localparam logic [K_W-1:0]    LAST_K    = K_W'(DIM - 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(N_ELEM * DIM - 1);

    localparam logic signed [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic signed [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

    typedef enum logic {
        OPERAND_A = 1'b0,
        OPERAND_B = 1'b1
    } t_operand;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_back_state;

    typedef struct packed {
        t_operand                  operand;
        logic [IDX_W-1:0]          index;
        logic signed [ELEM_W-1:0]  value;
        logic                      last;
    } t_load_item;

endpackage

>>> hdl/mm4_front.sv
`timescale 1ns / 1ps

module mm4_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_operand_sel,
    input  logic [mm4_pkg::IDX_W-1:0]        i_elem_index,
    input  logic signed [mm4_pkg::ELEM_W-1:0] i_elem_value,
    input  logic                             i_load_last,
    output logic                             o_q_valid,
    output mm4_pkg::t_load_item              o_q_item,
    input  logic                             i_q_pop
);

    mm4_pkg::t_load_item                r_queue [mm4_pkg::QUEUE_DEPTH];
    logic [mm4_pkg::QPTR_W-1:0]         r_wr_ptr;
    logic [mm4_pkg::QPTR_W-1:0]         r_rd_ptr;
    logic [mm4_pkg::QCNT_W-1:0]         r_count;
    logic [mm4_pkg::QCNT_W-1:0]         n_count;
    logic                               w_push;
    logic                               w_pop;
    mm4_pkg::t_load_item                w_item;

    assign o_in_stall = (r_count == mm4_pkg::QCNT_W'(mm4_pkg::QUEUE_DEPTH));
    assign w_push     = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != '0);
    assign w_pop      = i_q_pop && o_q_valid;
    assign o_q_item   = r_queue[r_rd_ptr];

    always_comb begin
        w_item.operand = i_operand_sel ? mm4_pkg::OPERAND_B : mm4_pkg::OPERAND_A;
        w_item.index   = i_elem_index;
        w_item.value   = i_elem_value;
        w_item.last    = i_load_last;
        n_count        = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

>>> hdl/mm4_back.sv
`timescale 1ns / 1ps

module mm4_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  mm4_pkg::t_load_item               i_q_item,
    output logic                              o_q_pop,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [mm4_pkg::IDX_W-1:0]         o_out_index,
    output logic signed [mm4_pkg::ELEM_W-1:0] o_out_value,
    output logic                              o_out_saturated,
    output logic                              o_out_last
);

    logic signed [mm4_pkg::ELEM_W-1:0] r_mem_a [mm4_pkg::N_ELEM];
    logic signed [mm4_pkg::ELEM_W-1:0] r_mem_b [mm4_pkg::N_ELEM];

    mm4_pkg::t_back_state              r_state;
    mm4_pkg::t_back_state              n_state;
    logic [mm4_pkg::STEP_W-1:0]        r_step;
    logic                              w_adv;
    logic                              w_issue;
    logic                              w_start;
    logic [mm4_pkg::IDX_W-1:0]         w_pos;
    logic [mm4_pkg::K_W-1:0]           w_k;
    logic [mm4_pkg::IDX_W-1:0]         w_addr_a;
    logic [mm4_pkg::IDX_W-1:0]         w_addr_b;

    logic signed [mm4_pkg::ELEM_W-1:0] r_rd_a;
    logic signed [mm4_pkg::ELEM_W-1:0] r_rd_b;
    logic                              r_v1;
    logic [mm4_pkg::IDX_W-1:0]         r_pos1;
    logic [mm4_pkg::K_W-1:0]           r_k1;

    logic signed [mm4_pkg::PROD_W-1:0] r_prod;
    logic                              r_v2;
    logic [mm4_pkg::IDX_W-1:0]         r_pos2;
    logic [mm4_pkg::K_W-1:0]           r_k2;

    logic signed [mm4_pkg::ACC_W-1:0]  r_acc;
    logic signed [mm4_pkg::ACC_W-1:0]  w_prod_ext;
    logic                              r_v3;
    logic [mm4_pkg::IDX_W-1:0]         r_pos3;

    logic signed [mm4_pkg::ACC_W-1:0]  w_shifted;
    logic [mm4_pkg::ACC_W-mm4_pkg::ELEM_W:0] w_upper;
    logic                              w_fits;
    logic signed [mm4_pkg::ELEM_W-1:0] w_sat_value;

    assign w_adv    = !(o_out_valid && i_out_stall);
    assign w_pos    = r_step[mm4_pkg::STEP_W-1:mm4_pkg::K_W];
    assign w_k      = r_step[mm4_pkg::K_W-1:0];
    assign w_addr_b = {w_k, w_pos[mm4_pkg::K_W-1:0]};
    assign w_addr_a = {w_pos[mm4_pkg::IDX_W-1:mm4_pkg::K_W], w_k};

    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        w_issue = 1'b0;
        w_start = 1'b0;
        case (r_state)
            mm4_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_item.last) begin
                        w_start = 1'b1;
                        n_state = mm4_pkg::ST_RUN;
                    end
                end
            end
            mm4_pkg::ST_RUN: begin
                w_issue = 1'b1;
                if (w_adv && (r_step == mm4_pkg::LAST_STEP)) begin
                    n_state = mm4_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mm4_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mm4_pkg::ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (w_start) begin
                r_step <= '0;
            end else if (w_issue && w_adv) begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            if (i_q_item.operand == mm4_pkg::OPERAND_B) begin
                r_mem_b[i_q_item.index] <= i_q_item.value;
            end else begin
                r_mem_a[i_q_item.index] <= i_q_item.value;
            end
        end
        if (w_adv) begin
            r_rd_a <= r_mem_a[w_addr_a];
            r_rd_b <= r_mem_b[w_addr_b];
        end
    end

    assign w_prod_ext = {{(mm4_pkg::ACC_W-mm4_pkg::PROD_W){r_prod[mm4_pkg::PROD_W-1]}}, r_prod};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pos1 <= w_pos;
            r_k1   <= w_k;
            r_prod <= r_rd_a * r_rd_b;
            r_pos2 <= r_pos1;
            r_k2   <= r_k1;
            if (r_v2) begin
                r_acc <= (r_k2 == '0) ? w_prod_ext : r_acc + w_prod_ext;
            end
            r_pos3 <= r_pos2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            o_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_v1        <= w_issue;
            r_v2        <= r_v1;
            r_v3        <= r_v2 && (r_k2 == mm4_pkg::LAST_K);
            o_out_valid <= r_v3;
        end
    end

    always_comb begin
        w_shifted = r_acc >>> FRAC_BITS;
        w_upper   = w_shifted[mm4_pkg::ACC_W-1:mm4_pkg::ELEM_W-1];
        w_fits    = (&w_upper) || !(|w_upper);
        if (w_fits) begin
            w_sat_value = w_shifted[mm4_pkg::ELEM_W-1:0];
        end else if (w_shifted[mm4_pkg::ACC_W-1]) begin
            w_sat_value = mm4_pkg::ELEM_MIN;
        end else begin
            w_sat_value = mm4_pkg::ELEM_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_v3) begin
            o_out_index     <= r_pos3;
            o_out_value     <= w_sat_value;
            o_out_saturated <= !w_fits;
            o_out_last      <= (r_pos3 == mm4_pkg::LAST_POS);
        end
    end

endmodule

>>> hdl/matrix_multiply_4x4_top.sv
`timescale 1ns / 1ps

// Input channel: one matrix element per transaction (operand select, flat index
// 4*row + column, Q16.16 value, load_last). Elements enter a four-deep queue at
// one per cycle; o_in_stall rises only while that queue is full.
// A transaction with load_last set writes its element and then starts the
// multiply. The product is computed on one shared 32x32 multiplier, one
// multiply-accumulate per cycle unless the output stalls; loads keep queuing
// while a multiply runs and are applied once it finishes.
// Output channel: sixteen result transactions in index order 0..15, each
// issued once the four products of its dot product are accumulated.
// o_out_last marks index 15; o_out_saturated marks a clipped value.
// While a result is valid and i_out_stall is high, the result register holds
// and the back-end pipeline freezes; nothing is lost or reordered.
// Reset (synchronous, active low) empties the queue and the pipeline; the
// matrix stores keep no reset value and must be written before use.

module matrix_multiply_4x4_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_operand_sel,
    input  logic [mm4_pkg::IDX_W-1:0]         i_elem_index,
    input  logic signed [mm4_pkg::ELEM_W-1:0] i_elem_value,
    input  logic                              i_load_last,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [mm4_pkg::IDX_W-1:0]         o_out_index,
    output logic signed [mm4_pkg::ELEM_W-1:0] o_out_value,
    output logic                              o_out_saturated,
    output logic                              o_out_last
);

    logic                q_valid;
    logic                q_pop;
    mm4_pkg::t_load_item q_item;

    mm4_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operand_sel (i_operand_sel),
        .i_elem_index  (i_elem_index),
        .i_elem_value  (i_elem_value),
        .i_load_last   (i_load_last),
        .o_q_valid     (q_valid),
        .o_q_item      (q_item),
        .i_q_pop       (q_pop)
    );

    mm4_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_item        (q_item),
        .o_q_pop         (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_index     (o_out_index),
        .o_out_value     (o_out_value),
        .o_out_saturated (o_out_saturated),
        .o_out_last      (o_out_last)
    );

endmodule

>>> hdl/mm4_checker.sv
`timescale 1ns / 1ps
`include "matrix_multiply_4x4_top_assert.svh"

module mm4_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [mm4_pkg::IDX_W-1:0]         o_out_index,
    input logic signed [mm4_pkg::ELEM_W-1:0] o_out_value,
    input logic                              o_out_saturated,
    input logic                              o_out_last
);

    logic [mm4_pkg::IDX_W-1:0] r_exp_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_idx <= '0;
        end else if (o_out_valid && !i_out_stall) begin
            r_exp_idx <= r_exp_idx + 1'b1;
        end
    end

    `MM4_ASSERT_NEXT(a_valid_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `MM4_ASSERT_NEXT(a_payload_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_index) && $stable(o_out_value) && $stable(o_out_saturated))
    `MM4_ASSERT_SAME(a_index_order, i_clk, i_rst_n, o_out_valid, o_out_index == r_exp_idx)
    `MM4_ASSERT_SAME(a_last_at_end, i_clk, i_rst_n, o_out_valid, o_out_last == (o_out_index == mm4_pkg::LAST_POS))
    `MM4_ASSERT_SAME(a_sat_clipped, i_clk, i_rst_n, o_out_valid && o_out_saturated, (o_out_value == mm4_pkg::ELEM_MAX) || (o_out_value == mm4_pkg::ELEM_MIN))

endmodule

bind matrix_multiply_4x4_top mm4_checker u_mm4_checker (.*);
